// File: sv/multi_flow_token_policer_macros.svh
`ifndef MULTI_FLOW_TOKEN_POLICER_MACROS_SVH
`define MULTI_FLOW_TOKEN_POLICER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MFTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MFTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mftp_pkg.sv
package mftp_pkg;

    localparam int DEFAULT_MAX_FLOWS = 16;
    localparam logic [15:0] PACKET_SIZE_RESET = 16'd1472;

    localparam int TOKEN_W = 40;
    localparam int PORT_W = 16;
    localparam int REFILL_W = 32;
    localparam int SLOT_W = 4;
    localparam int LEN_W = 16;
    localparam int AF_W = 5;
    localparam int CFG_W = 2 * PORT_W + REFILL_W;

    localparam logic [0:0] REG_ACTIVE_FLOWS = 1'b0;
    localparam logic [0:0] REG_PACKET_SIZE = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_PACKET = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        VERDICT_FORWARD = 3'd0,
        VERDICT_DROP = 3'd1,
        VERDICT_WRONG_LEN = 3'd2,
        VERDICT_NO_FLOW = 3'd3,
        VERDICT_LOADED = 3'd4,
        VERDICT_REFILLED = 3'd5
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_TICK,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        op_t op;
        logic [SLOT_W-1:0] slot;
        logic [PORT_W-1:0] ingress_port;
        logic [PORT_W-1:0] egress_port;
        logic [REFILL_W-1:0] refill;
        logic [LEN_W-1:0] length;
    } item_t;

    typedef struct packed {
        verdict_t verdict;
        logic [SLOT_W-1:0] slot;
        logic [PORT_W-1:0] port;
        logic signed [TOKEN_W-1:0] tokens;
    } result_t;

endpackage

// File: sv/mftp_ram.sv
module mftp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mftp_ctrl.sv
module mftp_ctrl
    import mftp_pkg::*;
#(
    parameter int MAX_FLOWS = DEFAULT_MAX_FLOWS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  item_t            item,
    output logic             busy,
    input  logic [AF_W-1:0]  active_flows,
    input  logic [LEN_W-1:0] packet_size,
    output logic             res_valid,
    output result_t          res,
    input  logic             res_ready
);

    localparam int AW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CW = $clog2(MAX_FLOWS + 1);
    localparam int LW = (CW > AF_W) ? CW : AF_W;
    localparam logic signed [TOKEN_W:0] TOKEN_FLOOR = -(41'sd1 <<< (TOKEN_W - 1));

    ctrl_state_t state_reg, state_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic signed [TOKEN_W-1:0] hit_tok_reg, hit_tok_next;
    logic [PORT_W-1:0] hit_egr_reg, hit_egr_next;
    result_t res_reg, res_next;
    logic [MAX_FLOWS-1:0] tok_vld_reg;

    logic [LW-1:0] af_wide;
    logic [LW-1:0] live_wide;
    logic [CW-1:0] live;

    logic cfg_we;
    logic [AW-1:0] cfg_waddr;
    logic [CFG_W-1:0] cfg_wdata;
    logic [CFG_W-1:0] cfg_rdata;
    logic [PORT_W-1:0] rd_ingress;
    logic [PORT_W-1:0] rd_egress;
    logic [REFILL_W-1:0] rd_refill;

    logic tok_we;
    logic [AW-1:0] tok_waddr;
    logic [TOKEN_W-1:0] tok_wdata;
    logic [TOKEN_W-1:0] tok_rdata;

    logic signed [TOKEN_W:0] diff;
    logic signed [TOKEN_W-1:0] tok_after;
    logic tok_pos;

    assign af_wide = LW'(active_flows);
    assign live_wide = (af_wide > LW'(MAX_FLOWS)) ? LW'(MAX_FLOWS) : af_wide;
    assign live = CW'(live_wide);

    assign {rd_ingress, rd_egress, rd_refill} = cfg_rdata;

    assign diff = {hit_tok_reg[TOKEN_W-1], hit_tok_reg}
                  - $signed({{(TOKEN_W + 1 - LEN_W){1'b0}}, packet_size});
    assign tok_after = (diff < TOKEN_FLOOR) ? TOKEN_FLOOR[TOKEN_W-1:0]
                                            : diff[TOKEN_W-1:0];
    assign tok_pos = !tok_after[TOKEN_W-1] && (tok_after != '0);

    mftp_ram #(
        .WIDTH(CFG_W),
        .DEPTH(MAX_FLOWS)
    ) u_cfg_ram (
        .clk(clk),
        .we(cfg_we),
        .waddr(cfg_waddr),
        .wdata(cfg_wdata),
        .raddr(issue_reg[AW-1:0]),
        .rdata(cfg_rdata)
    );

    mftp_ram #(
        .WIDTH(TOKEN_W),
        .DEPTH(MAX_FLOWS)
    ) u_tok_ram (
        .clk(clk),
        .we(tok_we),
        .waddr(tok_waddr),
        .wdata(tok_wdata),
        .raddr(issue_reg[AW-1:0]),
        .rdata(tok_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            tok_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            if (tok_we)
            begin
                tok_vld_reg[tok_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        port_reg <= port_next;
        len_reg <= len_next;
        hit_idx_reg <= hit_idx_next;
        hit_tok_reg <= hit_tok_next;
        hit_egr_reg <= hit_egr_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        issue_next = issue_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        port_next = port_reg;
        len_next = len_reg;
        hit_idx_next = hit_idx_reg;
        hit_tok_next = hit_tok_reg;
        hit_egr_next = hit_egr_reg;
        res_next = res_reg;
        cfg_we = 1'b0;
        cfg_waddr = AW'(item.slot);
        cfg_wdata = {item.ingress_port, item.egress_port, item.refill};
        tok_we = 1'b0;
        tok_waddr = cmp_idx_reg;
        tok_wdata = {{(TOKEN_W - REFILL_W){1'b0}}, rd_refill};
        res_valid = 1'b0;

        // walk the slot table one entry per cycle
        if ((state_reg == ST_SCAN || state_reg == ST_TICK) && issue_reg < live)
        begin
            cmp_vld_next = 1'b1;
            cmp_idx_next = issue_reg[AW-1:0];
            issue_next = issue_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                issue_next = '0;
                if (item_valid)
                begin
                    unique case (item.op)
                        OP_LOAD:
                        begin
                            cfg_we = (32'(item.slot) < 32'(MAX_FLOWS));
                            res_next = '{VERDICT_LOADED, '0, '0, '0};
                            state_next = ST_EMIT;
                        end
                        OP_PACKET:
                        begin
                            port_next = item.ingress_port;
                            len_next = item.length;
                            res_next = '{VERDICT_NO_FLOW, '0, '0, '0};
                            state_next = (live == '0) ? ST_EMIT : ST_SCAN;
                        end
                        OP_TICK:
                        begin
                            res_next = '{VERDICT_REFILLED, '0, '0, '0};
                            state_next = (live == '0) ? ST_EMIT : ST_TICK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cmp_vld_reg && rd_ingress == port_reg)
                begin
                    hit_idx_next = cmp_idx_reg;
                    hit_tok_next = tok_vld_reg[cmp_idx_reg] ? tok_rdata : '0;
                    hit_egr_next = rd_egress;
                    state_next = ST_HIT;
                end
                else if (!cmp_vld_reg && issue_reg >= live)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_HIT:
            begin
                if (len_reg != packet_size)
                begin
                    res_next = '{VERDICT_WRONG_LEN, SLOT_W'(hit_idx_reg), '0, hit_tok_reg};
                end
                else
                begin
                    tok_we = 1'b1;
                    tok_waddr = hit_idx_reg;
                    tok_wdata = tok_after;
                    if (tok_pos)
                    begin
                        res_next = '{VERDICT_FORWARD, SLOT_W'(hit_idx_reg), hit_egr_reg,
                                     tok_after};
                    end
                    else
                    begin
                        res_next = '{VERDICT_DROP, SLOT_W'(hit_idx_reg), '0, tok_after};
                    end
                end
                state_next = ST_EMIT;
            end
            ST_TICK:
            begin
                if (cmp_vld_reg)
                begin
                    tok_we = 1'b1;
                end
                else if (issue_reg >= live)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign res = res_reg;

endmodule

// File: sv/multi_flow_token_policer.sv
// Per-flow token policer with up to MAX_FLOWS slots. A load item writes a slot's ingress
// port, egress port and refill amount; a tick item sets every active slot's token count
// to its refill amount; a packet item is matched against the active slots (lowest slot
// wins) and, if its length equals packet_size, is charged packet_size tokens and
// forwarded while the count stays above zero; other lengths give a wrong-length verdict.
// Each item gives one result, except op 3, which is absorbed. Slot data sits in one
// RAM and token counts in another, both walked through a single read port one slot per
// cycle; a finished result waits while rsp_stall holds the output. Token counts read
// as zero after reset through per-slot flags, so no clearing pass runs. Configure only
// while idle.
`include "multi_flow_token_policer_macros.svh"

module multi_flow_token_policer
    import mftp_pkg::*;
#(
    parameter int MAX_FLOWS = DEFAULT_MAX_FLOWS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [1:0]                 op,
    input  logic [SLOT_W-1:0]          slot,
    input  logic [PORT_W-1:0]          ingress_port,
    input  logic [PORT_W-1:0]          egress_port,
    input  logic [REFILL_W-1:0]        refill,
    input  logic [LEN_W-1:0]           length,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [2:0]                 verdict,
    output logic [SLOT_W-1:0]          matched_slot,
    output logic [PORT_W-1:0]          out_port,
    output logic signed [TOKEN_W-1:0]  tokens_left,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [AF_W-1:0] active_flows_reg;
    logic [LEN_W-1:0] packet_size_reg;
    logic rsp_valid_reg;
    result_t rsp_reg;

    item_t item;
    logic busy;
    logic res_valid;
    result_t res;
    logic out_free;
    logic cfg_write;

    logic in_accept;
    logic rsp_forward;
    logic rsp_drop;
    logic rsp_tok_pos;

    assign item = '{op_t'(op), slot, ingress_port, egress_port, refill, length};

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    mftp_ctrl #(
        .MAX_FLOWS(MAX_FLOWS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(req_valid),
        .item(item),
        .busy(busy),
        .active_flows(active_flows_reg),
        .packet_size(packet_size_reg),
        .res_valid(res_valid),
        .res(res),
        .res_ready(out_free)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_flows_reg <= '0;
            packet_size_reg <= PACKET_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_ACTIVE_FLOWS: active_flows_reg <= pwdata[AF_W-1:0];
                REG_PACKET_SIZE: packet_size_reg <= pwdata[LEN_W-1:0];
                default: packet_size_reg <= packet_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ACTIVE_FLOWS: prdata = {{(32 - AF_W){1'b0}}, active_flows_reg};
            REG_PACKET_SIZE: prdata = {{(32 - LEN_W){1'b0}}, packet_size_reg};
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            rsp_reg <= res;
        end
    end

    assign req_stall = busy;
    assign rsp_valid = rsp_valid_reg;
    assign verdict = rsp_reg.verdict;
    assign matched_slot = rsp_reg.slot;
    assign out_port = rsp_reg.port;
    assign tokens_left = rsp_reg.tokens;

    assign in_accept = req_valid && !req_stall;
    assign rsp_forward = rsp_valid && (verdict == VERDICT_FORWARD);
    assign rsp_drop = rsp_valid && (verdict == VERDICT_DROP);
    assign rsp_tok_pos = !tokens_left[TOKEN_W-1] && (tokens_left != '0);

    `MFTP_ASSERT_NEXT(a_busy_after_accept, in_accept && op != OP_NONE, req_stall, "not busy")
    `MFTP_ASSERT_NOW(a_forward_has_tokens, rsp_forward, rsp_tok_pos, "forward, no tokens")
    `MFTP_ASSERT_NOW(a_drop_no_tokens, rsp_drop, !rsp_tok_pos, "drop with tokens left")

endmodule
